@@ design/svenc_pkg.sv @@
package svenc_pkg;

   localparam int unsigned MAG_W   = 32;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned BYTE_W  = 8;

   localparam logic [MAG_W-1:0] LIMIT_1 = 32'h0000_0040;
   localparam logic [MAG_W-1:0] LIMIT_2 = 32'h0000_2000;
   localparam logic [MAG_W-1:0] LIMIT_3 = 32'h0010_0000;
   localparam logic [MAG_W-1:0] LIMIT_4 = 32'h0800_0000;

   localparam logic [COUNT_W-1:0] BYTES_1 = 3'd1;
   localparam logic [COUNT_W-1:0] BYTES_2 = 3'd2;
   localparam logic [COUNT_W-1:0] BYTES_3 = 3'd3;
   localparam logic [COUNT_W-1:0] BYTES_4 = 3'd4;
   localparam logic [COUNT_W-1:0] BYTES_5 = 3'd5;

   localparam logic CONT_FLAG = 1'b1;
   localparam logic STOP_FLAG = 1'b0;

   typedef struct packed {
      logic [MAG_W-1:0]   mag;
      logic               neg;
      logic [COUNT_W-1:0] nbytes;
   } item_type;

endpackage

@@ design/signed_varint_encoder_unit.sv @@
// Signed varint encoder: one signed 32-bit value in, 1 to 5 bytes out.
// Input channel req_: req_value is taken on a clock edge with req_valid
// high and req_stall low. Output channel rsp_: one byte per transfer,
// most significant 7-bit group first with bit 7 set, then a final byte
// with bit 7 clear, bit 6 the sign and bits 5..0 the low magnitude bits;
// rsp_is_last marks that final byte.
// An item passes the input register, the serializer and the output
// register on its way out. Throughput: one output byte per cycle while
// rsp_stall is low; the next item waits in the input register and the
// serializer takes it while sending the last byte of the item before.
// A byte held by rsp_stall stays in the output register unchanged and
// the serializer pauses; once the input register is also full, req_stall
// rises until the serializer takes that item.
// Reset (synchronous, active high) empties the input register, the
// serializer and the output register; no clearing pass is needed.
module signed_varint_encoder_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_is_last
);
   import svenc_pkg::*;

   logic     item_valid;
   logic     item_take;
   item_type item;

   svenc_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   svenc_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item_take    (item_take),
      .item         (item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_last  (rsp_is_last)
   );

endmodule

@@ design/svenc_prep.sv @@
module svenc_prep (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [31:0]             req_value,
   output logic                           item_valid,
   input  logic                           item_take,
   output svenc_pkg::item_type            item
);
   import svenc_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   logic [MAG_W-1:0]   value_ff;
   logic [MAG_W-1:0]   value_in;
   logic               accept;
   logic [MAG_W-1:0]   mag;
   logic [COUNT_W-1:0] nbytes;

   assign req_stall = valid_ff && !item_take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (accept) begin
         valid_in = 1'b1;
         value_in = req_value;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   always_comb begin
      mag = value_ff[MAG_W-1] ? (~value_ff + 1'b1) : value_ff;
      priority if (mag < LIMIT_1) begin
         nbytes = BYTES_1;
      end else if (mag < LIMIT_2) begin
         nbytes = BYTES_2;
      end else if (mag < LIMIT_3) begin
         nbytes = BYTES_3;
      end else if (mag < LIMIT_4) begin
         nbytes = BYTES_4;
      end else begin
         nbytes = BYTES_5;
      end
   end

   assign item_valid  = valid_ff;
   assign item.mag    = mag;
   assign item.neg    = value_ff[MAG_W-1];
   assign item.nbytes = nbytes;

`ifndef SYNTH
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff)
      else $error("accepted transfer not held in input register");
   a_hold_untaken: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !item_take |=> valid_ff && $stable(value_ff))
      else $error("untaken item lost or changed");
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (nbytes >= BYTES_1) && (nbytes <= BYTES_5))
      else $error("byte count out of range");
`endif
endmodule

@@ design/svenc_emit.sv @@
module svenc_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_take,
   input  svenc_pkg::item_type   item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_is_last
);
   import svenc_pkg::*;

   logic               busy_ff;
   logic               busy_in;
   logic [COUNT_W-1:0] left_ff;
   logic [COUNT_W-1:0] left_in;
   logic [MAG_W-1:0]   mag_ff;
   logic [MAG_W-1:0]   mag_in;
   logic               neg_ff;
   logic               neg_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff;
   logic [BYTE_W-1:0]  rsp_byte_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;
   logic               out_free;
   logic               emit_go;
   logic               on_last;
   logic [BYTE_W-1:0]  next_byte;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_go   = busy_ff && out_free;
   assign on_last   = (left_ff == BYTES_1);
   assign item_take = item_valid && (!busy_ff || (emit_go && on_last));

   always_comb begin
      unique case (left_ff)
         BYTES_5: next_byte = {CONT_FLAG, 2'b00, mag_ff[31:27]};
         BYTES_4: next_byte = {CONT_FLAG, mag_ff[26:20]};
         BYTES_3: next_byte = {CONT_FLAG, mag_ff[19:13]};
         BYTES_2: next_byte = {CONT_FLAG, mag_ff[12:6]};
         BYTES_1: next_byte = {STOP_FLAG, neg_ff, mag_ff[5:0]};
         default: next_byte = {STOP_FLAG, neg_ff, mag_ff[5:0]};
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      left_in = left_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      if (item_take) begin
         busy_in = 1'b1;
         left_in = item.nbytes;
         mag_in  = item.mag;
         neg_in  = item.neg;
      end else if (emit_go) begin
         left_in = left_ff - 1'b1;
         if (on_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = next_byte;
         rsp_last_in  = on_last;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_is_last  = rsp_last_ff;

`ifndef SYNTH
   a_busy_left: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (left_ff >= BYTES_1) && (left_ff <= BYTES_5))
      else $error("byte counter out of range while busy");
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      emit_go && on_last |=> rsp_valid_ff && rsp_last_ff && !rsp_byte_ff[7])
      else $error("final byte not marked last");
   a_cont_flag: assert property (@(posedge clock) disable iff (reset)
      emit_go && !on_last |=> rsp_valid_ff && !rsp_last_ff && rsp_byte_ff[7])
      else $error("group byte lacks continuation bit");
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      item_take |=> busy_ff)
      else $error("taken item not started");
`endif
endmodule

@@ test/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_ITEMS = 100;
   localparam logic [31:0] BOUND_1 = 32'h0000_0040;
   localparam logic [31:0] BOUND_2 = 32'h0000_2000;
   localparam logic [31:0] BOUND_3 = 32'h0010_0000;
   localparam logic [31:0] BOUND_4 = 32'h0800_0000;

   typedef struct {
      logic [31:0] value;
      logic        drain;
   } value_item_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } coded_byte_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_out_byte;
   logic               rsp_is_last;

   value_item_type pending_values[$];
   coded_byte_type coded_q[$];
   coded_byte_type coded_head;
   int unsigned cycles = 0;
   int unsigned mismatches = 0;
   int unsigned send_idle = 0;
   int unsigned stall_left = 0;

   signed_varint_encoder_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_last  (rsp_is_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, and quiet windows with none
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (cycles[9:8] == 2'b11) return 0;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void encode_value(input logic [31:0] v);
      logic [31:0] mag;
      logic        neg;
      int          nbytes;
      int          sh;
      coded_byte_type cb;
      neg = v[31];
      mag = neg ? (~v + 32'd1) : v;
      if (mag < BOUND_1) nbytes = 1;
      else if (mag < BOUND_2) nbytes = 2;
      else if (mag < BOUND_3) nbytes = 3;
      else if (mag < BOUND_4) nbytes = 4;
      else nbytes = 5;
      for (int k = 0; k < nbytes - 1; k++) begin
         sh = 6 + 7 * (nbytes - 2 - k);
         cb.data = {1'b1, 7'((mag >> sh) & 32'h7F)};
         cb.last = 1'b0;
         coded_q.push_back(cb);
      end
      cb.data = {1'b0, neg, mag[5:0]};
      cb.last = 1'b1;
      coded_q.push_back(cb);
   endfunction

   function automatic logic [31:0] random_value();
      logic [31:0] mag;
      case ($urandom_range(0, 5))
         0: mag = $urandom_range(0, 32'h3F);
         1: mag = $urandom_range(32'h40, 32'h1FFF);
         2: mag = $urandom_range(32'h2000, 32'hF_FFFF);
         3: mag = $urandom_range(32'h10_0000, 32'h7FF_FFFF);
         4: mag = $urandom_range(32'h800_0000, 32'h7FFF_FFFF);
         default: return $urandom;
      endcase
      return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
   endfunction

   function automatic void add_value(input logic [31:0] v, input logic drain);
      value_item_type it;
      it.value = v;
      it.drain = drain;
      pending_values.push_back(it);
   endfunction

   function automatic void report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
   endfunction

   // driver: hold the payload while stalled, advance after each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
         send_idle <= 0;
      end else begin
         if (req_valid && !req_stall) encode_value(req_value);
         if (!req_valid || !req_stall) begin
            if (send_idle != 0) begin
               send_idle <= send_idle - 1;
               req_valid <= 1'b0;
            end else if (pending_values.size() != 0 &&
                         !(pending_values[0].drain && coded_q.size() != 0)) begin
               req_valid <= 1'b1;
               req_value <= pending_values[0].value;
               pending_values.pop_front();
               send_idle <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each byte transfer, then choose the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (coded_q.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %h last %b",
                                         rsp_out_byte, rsp_is_last));
            end else begin
               coded_head = coded_q.pop_front();
               if (rsp_out_byte !== coded_head.data || rsp_is_last !== coded_head.last)
                  report_mismatch($sformatf("byte exp %h act %h, last exp %b act %b",
                                            coded_head.data, rsp_out_byte,
                                            coded_head.last, rsp_is_last));
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            stall_left <= pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      add_value(32'h0000_0000, 1'b0);
      add_value(32'h0000_0001, 1'b0);
      add_value(32'hFFFF_FFFF, 1'b0);
      add_value(32'h0000_003F, 1'b0);
      add_value(32'hFFFF_FFC1, 1'b0);
      add_value(32'h0000_0040, 1'b0);
      add_value(32'hFFFF_FFC0, 1'b0);
      add_value(32'h0000_1FFF, 1'b0);
      add_value(32'h0000_2000, 1'b0);
      add_value(32'hFFFF_E000, 1'b0);
      add_value(32'h000F_FFFF, 1'b0);
      add_value(32'h0010_0000, 1'b0);
      add_value(32'hFFF0_0000, 1'b0);
      add_value(32'h07FF_FFFF, 1'b0);
      add_value(32'h0800_0000, 1'b0);
      add_value(32'hF800_0000, 1'b0);
      add_value(32'h7FFF_FFFF, 1'b0);
      add_value(32'h8000_0000, 1'b0);
      add_value(32'h8000_0001, 1'b0);
      add_value(32'hAAAA_AAAA, 1'b0);
      add_value(32'h5555_5555, 1'b0);
      for (int i = 0; i < RANDOM_ITEMS; i++)
         add_value(random_value(), (i == 0 || i == RANDOM_ITEMS / 2));
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pending_values.size() != 0 || req_valid || coded_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && coded_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

@@ files.f @@
design/svenc_pkg.sv
design/svenc_prep.sv
design/svenc_emit.sv
design/signed_varint_encoder_unit.sv
test/tb_top.sv
